// ===== sv/mlfd_pkg.sv =====
// ---------------------------------------------------------------------------
// mlfd_pkg: shared types for the length-prefixed message deframer
// Result kinds, parser phases, the sync word and the item structs that
// pass between the stages.
// ---------------------------------------------------------------------------
`default_nettype none

package mlfd_pkg;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_EMPTY  = 2'd1,
		KIND_SYNC   = 2'd2,
		KIND_CLOSED = 2'd3
	} result_kind_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'b001,
		PH_LEN  = 3'b010,
		PH_PAY  = 3'b100
	} phase_t;

	localparam int HDR_BYTES = 4;
	localparam int HDR_IDX_W = $clog2(HDR_BYTES);
	localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST = HDR_IDX_W'(HDR_BYTES - 1);

	// sync word, first byte on the wire first
	function automatic logic [7:0] sync_byte(input logic [HDR_IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = 8'h49;
			2'd1:    b = 8'h08;
			2'd2:    b = 8'h1e;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       link_closed;
	} in_item_t;

	typedef struct packed {
		logic         valid;
		result_kind_t kind;
		logic [7:0]   payload_byte;
		logic         last;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/magic_length_frame_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// magic_length_frame_deframer_unit: length-prefixed message deframer
// Hunts a four-byte sync word, reads a little-endian 32-bit length and
// forwards the payload bytes, marking the final one; reports empty
// messages, sync errors and link closure.
//
// Channel  Dir  tdata                  tuser             tlast
// s_       in   [7:0] stream_byte      [0] link_closed   -
// m_       out  [7:0] payload_byte     [1:0] result_kind last_of_message
//
// One transaction per cycle in, at most one result per cycle out.
// A byte passes the input register, then the parser step into the
// result register. The decode is a single pass through the phase logic.
// s_tready follows m_tready combinationally; a held result stalls input.
// Reset is asynchronous, active low; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module magic_length_frame_deframer_unit
	import mlfd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] stream_byte
	input  wire logic       s_tuser,   // [0] link_closed
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] payload_byte
	output logic [1:0]      m_tuser,   // [1:0] result_kind
	output logic            m_tlast
);

	in_item_t in_item, item_s1;
	logic     valid_s1;
	logic     down_free;
	logic     step;
	result_t  res, res_s2;

	assign in_item = '{stream_byte: s_tdata, link_closed: s_tuser};
	assign step    = valid_s1 && down_free;

	mlfd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.down_free (down_free),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	mlfd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res)
	);

	mlfd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.free      (down_free),
		.valid_s2  (m_tvalid),
		.out_ready (m_tready),
		.res_s2    (res_s2)
	);

	assign m_tdata = res_s2.payload_byte;
	assign m_tuser = res_s2.kind;
	assign m_tlast = res_s2.last;

endmodule

`default_nettype wire

// ===== sv/mlfd_in_stage.sv =====
// ---------------------------------------------------------------------------
// mlfd_in_stage: input register
// Captures one stream transaction and holds it until the parser takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module mlfd_in_stage
	import mlfd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	input  wire logic     down_free,
	output logic          valid_s1,
	output in_item_t      item_s1
);

	assign in_ready = !valid_s1 || down_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/mlfd_parser.sv =====
// ---------------------------------------------------------------------------
// mlfd_parser: frame state and per-byte decode
// Tracks sync word, length field and payload count; forms at most one
// result per consumed item.
// ---------------------------------------------------------------------------
`default_nettype none

module mlfd_parser
	import mlfd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_item_t item,
	output result_t       res
);

	phase_t                phase_q, phase_d;
	logic [HDR_IDX_W-1:0]  hdr_idx_q, hdr_idx_d;
	// length during the header, then payload bytes still to come
	logic [31:0]           count_q, count_d;
	logic [31:0]           len_full;

	always_comb begin
		len_full = count_q | ({24'd0, item.stream_byte} << {hdr_idx_q, 3'b000});

		phase_d   = phase_q;
		hdr_idx_d = hdr_idx_q;
		count_d   = count_q;
		res       = '{valid: 1'b0, kind: KIND_DATA, payload_byte: 8'd0, last: 1'b0};

		if (item.link_closed) begin
			phase_d   = PH_HUNT;
			hdr_idx_d = '0;
			count_d   = '0;
			res       = '{valid: 1'b1, kind: KIND_CLOSED, payload_byte: 8'd0, last: 1'b1};
		end else begin
			unique case (phase_q)
				PH_LEN: begin
					count_d   = len_full;
					hdr_idx_d = hdr_idx_q + 1'b1;
					if (hdr_idx_q == HDR_IDX_LAST) begin
						if (len_full == 32'd0) begin
							phase_d = PH_HUNT;
							res = '{valid: 1'b1, kind: KIND_EMPTY, payload_byte: 8'd0,
								last: 1'b1};
						end else begin
							phase_d = PH_PAY;
						end
					end
				end
				PH_PAY: begin
					count_d = count_q - 32'd1;
					res = '{valid: 1'b1, kind: KIND_DATA, payload_byte: item.stream_byte,
						last: (count_q == 32'd1)};
					if (count_q == 32'd1) begin
						phase_d   = PH_HUNT;
						hdr_idx_d = '0;
					end
				end
				default: begin
					if (item.stream_byte != sync_byte(hdr_idx_q)) begin
						hdr_idx_d = '0;
						res = '{valid: 1'b1, kind: KIND_SYNC, payload_byte: 8'd0, last: 1'b1};
					end else begin
						hdr_idx_d = hdr_idx_q + 1'b1;
						count_d   = '0;
						if (hdr_idx_q == HDR_IDX_LAST) begin
							phase_d = PH_LEN;
						end
					end
				end
			endcase
		end

		res.valid = res.valid && step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			hdr_idx_q <= '0;
			count_q   <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			count_q   <= count_d;
		end
	end

	a_closed_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.link_closed |=> phase_q == PH_HUNT && hdr_idx_q == '0)
		else $error("link close did not return to hunting");

	a_pay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> count_q != 32'd0)
		else $error("payload phase with no bytes left");

	a_nondata_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind != KIND_DATA |-> res.last && res.payload_byte == 8'd0)
		else $error("status result not marked last or carries data");

	a_final_byte: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.link_closed && phase_q == PH_PAY && count_q == 32'd1
		|=> phase_q == PH_HUNT && hdr_idx_q == '0)
		else $error("final payload byte did not end the frame");

endmodule

`default_nettype wire

// ===== sv/mlfd_out_stage.sv =====
// ---------------------------------------------------------------------------
// mlfd_out_stage: result register
// Holds one result until the downstream side takes the transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module mlfd_out_stage
	import mlfd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire result_t res,
	output logic         free,
	output logic         valid_s2,
	input  wire logic    out_ready,
	output result_t      res_s2
);

	assign free = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res.valid) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

// ===== dv/magic_length_frame_deframer_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// magic_length_frame_deframer_unit_tb: self-checking bench for the deframer
// Drives framed byte streams, noise, broken sync words and link closures
// with random idling on both channels. A transaction-level model of the parser
// predicts each result, and every output transaction is checked in order.
// ---------------------------------------------------------------------------

module magic_length_frame_deframer_unit_tb;
	import mlfd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;

	typedef enum logic [1:0] {
		HUNTING,
		LENGTH,
		PAYLOAD
	} parse_phase_t;

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   data;
		logic         last;
	} frame_result_t;

	localparam logic [7:0] SYNC_WORD [4] = '{8'h49, 8'h08, 8'h1e, 8'h00};

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	// parser model state
	parse_phase_t parse_phase;
	logic [1:0]   hdr_pos;
	logic [31:0]  len_acc;
	logic [31:0]  bytes_left;

	frame_result_t pending_results[$];
	int            mismatches;
	int            items_sent;
	int            cycle_count;
	bit            no_idle;

	magic_length_frame_deframer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void restart_hunt();
		parse_phase = HUNTING;
		hdr_pos     = 2'd0;
		len_acc     = 32'd0;
		bytes_left  = 32'd0;
	endfunction

	// advance the parser model by one input transaction
	function automatic void deframe_step(input logic [7:0] b, input logic closed);
		frame_result_t r;
		bit            hit;
		hit = 1'b0;
		r   = '0;
		if (closed) begin
			restart_hunt();
			r.kind = KIND_CLOSED;
			r.last = 1'b1;
			hit    = 1'b1;
		end else begin
			case (parse_phase)
				LENGTH: begin
					len_acc = len_acc | (32'(b) << (8 * hdr_pos));
					if (hdr_pos == 2'd3) begin
						hdr_pos = 2'd0;
						if (len_acc == 32'd0) begin
							restart_hunt();
							r.kind = KIND_EMPTY;
							r.last = 1'b1;
							hit    = 1'b1;
						end else begin
							bytes_left  = len_acc;
							parse_phase = PAYLOAD;
						end
					end else begin
						hdr_pos = hdr_pos + 2'd1;
					end
				end
				PAYLOAD: begin
					bytes_left = bytes_left - 32'd1;
					r.kind = KIND_DATA;
					r.data = b;
					r.last = (bytes_left == 32'd0);
					hit    = 1'b1;
					if (r.last)
						restart_hunt();
				end
				default: begin
					parse_phase = HUNTING;
					if (b != SYNC_WORD[hdr_pos]) begin
						restart_hunt();
						r.kind = KIND_SYNC;
						r.last = 1'b1;
						hit    = 1'b1;
					end else if (hdr_pos == 2'd3) begin
						parse_phase = LENGTH;
						hdr_pos     = 2'd0;
						len_acc     = 32'd0;
					end else begin
						hdr_pos = hdr_pos + 2'd1;
					end
				end
			endcase
		end
		if (hit)
			pending_results.push_back(r);
	endfunction

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_item(input logic [7:0] b, input logic closed);
		while (!no_idle && $urandom_range(0, 99) < 16) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= closed;
		do
			@(posedge clk);
		while (!s_tready);
		deframe_step(b, closed);
		items_sent++;
		@(negedge clk);
	endtask

	// sync word, length, payload; cut >= 0 replaces byte number cut onward by a closure
	task automatic send_frame(input logic [31:0] len, input int cut);
		longint total;
		logic [7:0] b;
		total = (cut >= 0) ? longint'(cut) : 64'd8 + longint'(len);
		for (longint i = 0; i < total; i++) begin
			if (i < 4)
				b = SYNC_WORD[i];
			else if (i < 8)
				b = len[8 * (i - 4) +: 8];
			else
				b = 8'($urandom);
			send_item(b, 1'b0);
		end
		if (cut >= 0)
			send_item(8'($urandom), 1'b1);
	endtask

	task automatic test_directed_cases();
		send_item(8'h5a, 1'b1);          // closure while idle
		send_item(8'h00, 1'b0);          // wrong first sync byte
		send_frame(32'd0, -1);           // empty message
		send_frame(32'hffff_ffff, 9);    // largest length, aborted after one byte
		send_frame(32'd1, -1);
		send_item(SYNC_WORD[0], 1'b0);   // mismatch deep in the sync word
		send_item(SYNC_WORD[1], 1'b0);
		send_item(8'hff, 1'b0);
		send_frame(32'd5, 6);            // closure inside the length field
		send_frame(32'd2, 2);            // closure inside the sync word
	endtask

	task automatic test_random_framing(input int n_items);
		int          stop;
		int unsigned pick;
		int          k;
		logic [31:0] len;
		logic [7:0]  b;
		stop = items_sent + n_items;
		while (items_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				k = $urandom_range(0, 99);
				if (k < 8)
					send_frame(32'd0, -1);
				else if (k < 80)
					send_frame(32'($urandom_range(1, 8)), -1);
				else if (k < 95)
					send_frame(32'($urandom_range(9, 40)), -1);
				else begin
					// huge length: abort soon after the header
					len = $urandom | 32'h0000_0100;
					send_frame(len, 8 + $urandom_range(0, 6));
				end
			end else if (pick < 82) begin
				repeat ($urandom_range(1, 4))
					send_item(8'($urandom), 1'b0);
			end else if (pick < 91) begin
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++)
					send_item(SYNC_WORD[i], 1'b0);
				b = 8'($urandom);
				if (b == SYNC_WORD[k])
					b = ~b;
				send_item(b, 1'b0);
			end else begin
				len = 32'($urandom_range(1, 20));
				send_frame(len, $urandom_range(0, 7 + int'(len)));
			end
		end
	endtask

	task automatic test_drain_pause();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_no_idle_burst(input int n_items);
		no_idle = 1'b1;
		test_random_framing(n_items);
		no_idle = 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		frame_result_t want;
		frame_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = result_kind_t'(m_tuser);
			got.data = m_tdata;
			got.last = m_tlast;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result kind=%0d data=%02h last=%0b",
						got.kind, got.data, got.last);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
						got.last !== want.last) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: expected kind=%0d data=%02h last=%0b, got kind=%0d data=%02h last=%0b",
							want.kind, want.data, want.last, got.kind, got.data, got.last);
				end
			end
		end
	end

	// receiver back-pressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= no_idle || ($urandom_range(0, 99) >= 16);
		end
	end

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = 8'h00;
		s_tuser     = 1'b0;
		no_idle     = 1'b0;
		mismatches  = 0;
		items_sent  = 0;
		cycle_count = 0;
		restart_hunt();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_random_framing(900);
		test_drain_pause();
		test_no_idle_burst(300);
		test_random_framing(500);

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/mlfd_pkg.sv
sv/mlfd_in_stage.sv
sv/mlfd_parser.sv
sv/mlfd_out_stage.sv
sv/magic_length_frame_deframer_unit.sv
dv/magic_length_frame_deframer_unit_tb.sv
